// ----- src/band_meter_ballistics_peak_hold_macros.svh -----
// Assertion macros for the band meter ballistics block.
`ifndef BAND_METER_BALLISTICS_PEAK_HOLD_MACROS_SVH
`define BAND_METER_BALLISTICS_PEAK_HOLD_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define BMBPH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define BMBPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bmbph_pkg.sv -----
// Types and constants of the band meter ballistics block.
package bmbph_pkg;

  localparam int BAND_W    = 6;
  localparam int LEVEL_W   = 16;
  localparam int DECAY_W   = 16;
  localparam int HOLD_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam int NUM_BANDS_DEF = 64;

  localparam logic [DECAY_W-1:0]        DECAY_RESET = 16'd85;
  localparam logic signed [LEVEL_W-1:0] FLOOR_RESET = -16'sd15360;
  localparam logic [HOLD_W-1:0]         HOLD_RESET  = 10'd120;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_STEP  = 2'd0,
    CFG_FLOOR_LEVEL = 2'd1,
    CFG_HOLD_FRAMES = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] sm;
    logic signed [LEVEL_W-1:0] pk;
    logic [HOLD_W-1:0]         cd;
  } band_state_t;

  localparam band_state_t STATE_RESET = '{sm: FLOOR_RESET, pk: FLOOR_RESET, cd: '0};

endpackage

// ----- src/band_meter_ballistics_peak_hold.sv -----
// Per-band meter ballistics: smoothed level with decay and peak hold.
// A result passes through 3 register stages (s1, s2, s3) after its item is accepted.
// Throughput: one item per cycle while the output is not stalled; per-band state read-modify-write is forwarded.
// Stages: state read, smoothed update, peak/hold update and state write.
// Reset: config registers to defaults, band state reads as floor and zero
// through per-band valid bits cleared at once; no clearing pass.
module band_meter_ballistics_peak_hold #(
  parameter int NUM_BANDS = bmbph_pkg::NUM_BANDS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [bmbph_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bmbph_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bmbph_pkg::BAND_W-1:0]         band_i,
  input  logic signed [bmbph_pkg::LEVEL_W-1:0] level_db_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bmbph_pkg::BAND_W-1:0]         band_out_o,
  output logic signed [bmbph_pkg::LEVEL_W-1:0] smoothed_db_o,
  output logic signed [bmbph_pkg::LEVEL_W-1:0] peak_db_o,
  output logic                                 peak_falling_o
);
  import bmbph_pkg::*;

  `include "band_meter_ballistics_peak_hold_macros.svh"

  localparam int AW = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;

  // configuration
  logic [DECAY_W-1:0]        decay_q;
  logic signed [LEVEL_W-1:0] floor_q;
  logic [HOLD_W-1:0]         hold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decay_q <= DECAY_RESET;
      floor_q <= FLOOR_RESET;
      hold_q  <= HOLD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_DECAY_STEP:  decay_q <= cfg_data_i;
        CFG_FLOOR_LEVEL: floor_q <= cfg_data_i;
        CFG_HOLD_FRAMES: hold_q  <= cfg_data_i[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic accept;
  logic in_range;

  logic                      s1_valid_q, s2_valid_q, s3_valid_q;
  logic [BAND_W-1:0]         s1_band_q, s2_band_q, s3_band_q;
  logic signed [LEVEL_W-1:0] s1_level_q;
  logic                      s1_hit_q;
  band_state_t               s1_mem_q;
  logic signed [LEVEL_W-1:0] s2_sm_q, s2_pk_q;
  logic [HOLD_W-1:0]         s2_cd_q;
  logic signed [LEVEL_W-1:0] s3_sm_q, s3_pk_q;
  logic [HOLD_W-1:0]         s3_cd_q;
  logic                      s3_falling_q;

  assign adv        = !s3_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign in_range   = 32'(band_i) < NUM_BANDS;

  // band state memory
  band_state_t          mem [NUM_BANDS];
  logic [NUM_BANDS-1:0] valid_q;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic                 wr_en;
  band_state_t          wr_data;

  assign rd_addr = AW'(band_i);
  assign wr_addr = AW'(s2_band_q);
  assign wr_en   = adv && s2_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  // stage 1: forward newer state, update smoothed level
  band_state_t               base, cur;
  logic signed [LEVEL_W+1:0] sm_ext, dec_ext, sm_t, lvl_ext;
  logic signed [LEVEL_W-1:0] sm_new;
  logic signed [LEVEL_W-1:0] pk_new;
  logic [HOLD_W-1:0]         cd_new, cd_dec;
  logic                      fall_new;

  always_comb begin
    base = s1_hit_q ? s1_mem_q : STATE_RESET;
    priority if (s2_valid_q && (s2_band_q == s1_band_q)) begin
      cur = '{sm: s2_sm_q, pk: pk_new, cd: cd_new};
    end else if (s3_valid_q && (s3_band_q == s1_band_q)) begin
      cur = '{sm: s3_sm_q, pk: s3_pk_q, cd: s3_cd_q};
    end else begin
      cur = base;
    end
    sm_ext  = (LEVEL_W+2)'(cur.sm);
    dec_ext = (LEVEL_W+2)'(decay_q);
    lvl_ext = (LEVEL_W+2)'(s1_level_q);
    sm_t    = sm_ext - dec_ext;
    if (s1_level_q > cur.sm) begin
      sm_new = s1_level_q;
    end else if (sm_t > lvl_ext) begin
      sm_new = sm_t[LEVEL_W-1:0];
    end else begin
      sm_new = s1_level_q;
    end
  end

  // stage 2: peak and hold countdown
  logic signed [LEVEL_W:0] pk_ext, half_ext, pk_t, floor_ext;

  always_comb begin
    pk_ext    = (LEVEL_W+1)'(s2_pk_q);
    half_ext  = (LEVEL_W+1)'(decay_q[DECAY_W-1:1]);
    floor_ext = (LEVEL_W+1)'(floor_q);
    pk_t      = pk_ext - half_ext;
    cd_dec    = (s2_cd_q != '0) ? s2_cd_q - 1'b1 : '0;
    pk_new    = s2_pk_q;
    cd_new    = cd_dec;
    fall_new  = 1'b0;
    if (s2_sm_q >= s2_pk_q) begin
      pk_new = s2_sm_q;
      cd_new = hold_q;
    end else if (cd_dec == '0) begin
      pk_new   = (pk_t > floor_ext) ? pk_t[LEVEL_W-1:0] : floor_q;
      fall_new = 1'b1;
    end
    wr_data = '{sm: s2_sm_q, pk: pk_new, cd: cd_new};
  end

  // pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i && in_range;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_band_q    <= band_i;
      s1_level_q   <= level_db_i;
      s1_hit_q     <= valid_q[rd_addr];
      s2_band_q    <= s1_band_q;
      s2_sm_q      <= sm_new;
      s2_pk_q      <= cur.pk;
      s2_cd_q      <= cur.cd;
      s3_band_q    <= s2_band_q;
      s3_sm_q      <= s2_sm_q;
      s3_pk_q      <= pk_new;
      s3_cd_q      <= cd_new;
      s3_falling_q <= fall_new;
    end
  end

  assign out_valid_o    = s3_valid_q;
  assign band_out_o     = s3_band_q;
  assign smoothed_db_o  = s3_sm_q;
  assign peak_db_o      = s3_pk_q;
  assign peak_falling_o = s3_falling_q;

  `BMBPH_ASSERT_NOW(a_fall_cd_zero, s3_valid_q && s3_falling_q, s3_cd_q == '0,
    "peak falling with hold countdown running")
  `BMBPH_ASSERT_NOW(a_band_range, s3_valid_q, 32'(s3_band_q) < NUM_BANDS,
    "result for band out of range")
  `BMBPH_ASSERT_NEXT(a_stall_freeze, s3_valid_q && !out_ready_i,
    $stable(s1_valid_q) && $stable(s1_band_q) && $stable(s2_valid_q) && $stable(s2_sm_q),
    "pipeline moved during output stall")

endmodule

// ----- verif/meter_ballistics_checker.sv -----
// Checker for the band meter: predicts each frame result and compares it at the output.
module meter_ballistics_checker #(
  parameter int NUM_BANDS = bmbph_pkg::NUM_BANDS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [bmbph_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bmbph_pkg::CFG_DAT_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_ready_i,
  input  logic [bmbph_pkg::BAND_W-1:0]         band_i,
  input  logic signed [bmbph_pkg::LEVEL_W-1:0] level_db_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_ready_i,
  input  logic [bmbph_pkg::BAND_W-1:0]         band_out_i,
  input  logic signed [bmbph_pkg::LEVEL_W-1:0] smoothed_db_i,
  input  logic signed [bmbph_pkg::LEVEL_W-1:0] peak_db_i,
  input  logic                                 peak_falling_i,
  output int                                   fail_count_o,
  output int                                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bmbph_pkg::*;

  typedef struct packed {
    logic [BAND_W-1:0]         band;
    logic signed [LEVEL_W-1:0] smoothed;
    logic signed [LEVEL_W-1:0] peak;
    logic                      falling;
  } meter_frame_t;

  meter_frame_t frame_q[$];

  int smooth_lvl[NUM_BANDS];
  int peak_lvl[NUM_BANDS];
  int hold_left[NUM_BANDS];
  int decay_q8;
  int floor_q8;
  int hold_len;
  int fails;

  function automatic meter_frame_t advance_band(int b, int lvl);
    meter_frame_t f;
    int sm;
    int pk;
    int cd;
    int t;
    sm = smooth_lvl[b];
    if (lvl > sm) begin
      sm = lvl;
    end else begin
      t = sm - decay_q8;
      sm = (t > lvl) ? t : lvl;
    end
    pk = peak_lvl[b];
    cd = hold_left[b];
    f.falling = 1'b0;
    if (sm >= pk) begin
      pk = sm;
      cd = hold_len;
    end else begin
      if (cd > 0) cd--;
      if (cd == 0) begin
        t = pk - (decay_q8 >> 1);
        pk = (t > floor_q8) ? t : floor_q8;
        f.falling = 1'b1;
      end
    end
    smooth_lvl[b] = sm;
    peak_lvl[b] = pk;
    hold_left[b] = cd;
    f.band = BAND_W'(b);
    f.smoothed = LEVEL_W'(sm);
    f.peak = LEVEL_W'(pk);
    return f;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    meter_frame_t want;
    if (!rst_ni) begin
      decay_q8 = DECAY_RESET;
      floor_q8 = FLOOR_RESET;
      hold_len = HOLD_RESET;
      for (int i = 0; i < NUM_BANDS; i++) begin
        smooth_lvl[i] = FLOOR_RESET;
        peak_lvl[i] = FLOOR_RESET;
        hold_left[i] = 0;
      end
      frame_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (frame_q.size() == 0) begin
          $display("%0t: expected no item, got band_out %0d smoothed %0d peak %0d",
                   $time, band_out_i, smoothed_db_i, peak_db_i);
          fails++;
        end else begin
          want = frame_q.pop_front();
          compare_field("band_out", want.band, band_out_i);
          compare_field("smoothed_db", want.smoothed, smoothed_db_i);
          compare_field("peak_db", want.peak, peak_db_i);
          compare_field("peak_falling", want.falling, peak_falling_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DECAY_STEP:  decay_q8 = cfg_data_i;
          CFG_FLOOR_LEVEL: floor_q8 = $signed(cfg_data_i);
          CFG_HOLD_FRAMES: hold_len = cfg_data_i[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i && band_i < NUM_BANDS) begin
        frame_q.push_back(advance_band(band_i, level_db_i));
      end
    end
    fail_count_o <= fails;
    pending_o <= frame_q.size();
  end

endmodule

// ----- verif/band_meter_ballistics_peak_hold_tb.sv -----
// Testbench top for the band meter: stimulus, pacing of both channels and the verdict.
module band_meter_ballistics_peak_hold_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmbph_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_FRAMES = 1900;
  localparam int PHASES = 8;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [CFG_DAT_W-1:0]      cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [BAND_W-1:0]         band_i = '0;
  logic signed [LEVEL_W-1:0] level_db_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [BAND_W-1:0]         band_out_o;
  logic signed [LEVEL_W-1:0] smoothed_db_o;
  logic signed [LEVEL_W-1:0] peak_db_o;
  logic                      peak_falling_o;

  int fail_count;
  int pending;
  int burst_left = 0;
  int walk[64];
  rx_mode_e rx_mode = RX_OPEN;
  logic [7:0] rx_tick = '0;

  band_meter_ballistics_peak_hold dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .band_i, .level_db_i,
    .out_valid_o, .out_ready_i, .band_out_o, .smoothed_db_o, .peak_db_o, .peak_falling_o
  );

  meter_ballistics_checker check_u (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .band_i, .level_db_i,
    .out_valid_i(out_valid_o), .out_ready_i, .band_out_i(band_out_o),
    .smoothed_db_i(smoothed_db_o), .peak_db_i(peak_db_o), .peak_falling_i(peak_falling_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick == 8'd0) rx_mode <= rx_mode_e'($urandom_range(3));
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(1));
      RX_SPARSE: out_ready_i <= ($urandom_range(9) == 0);
      default:   out_ready_i <= (rx_tick[2:0] != 3'd5);
    endcase
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_setting(logic [15:0] decay, logic [15:0] floor_raw, logic [9:0] hold);
    write_reg(CFG_DECAY_STEP, decay);
    write_reg(CFG_FLOOR_LEVEL, floor_raw);
    write_reg(CFG_HOLD_FRAMES, {6'($urandom), hold});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_frame(logic [BAND_W-1:0] b, logic signed [LEVEL_W-1:0] lvl);
    band_i <= b;
    level_db_i <= lvl;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(9) < 3) ? $urandom_range(40, 200) : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic pick_setting(int ph);
    logic [15:0] decay;
    logic [15:0] floor_raw;
    logic [9:0] hold;
    case ($urandom_range(3))
      0: decay = '0;
      1: decay = '1;
      2: decay = 16'($urandom_range(1, 600));
      default: decay = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: floor_raw = 16'h8000;
      1: floor_raw = 16'h7fff;
      2: floor_raw = 16'(int'($urandom_range(20000)) - 20000);
      default: floor_raw = 16'($urandom);
    endcase
    case ($urandom_range(3))
      0: hold = '0;
      1: hold = '1;
      2: hold = 10'($urandom_range(6));
      default: hold = 10'($urandom_range(1023));
    endcase
    if (ph == 0) begin
      decay = '1;
      floor_raw = 16'h7fff;
      hold = '0;
    end
    if (ph == 1) begin
      decay = '0;
      floor_raw = 16'h8000;
      hold = '1;
    end
    apply_setting(decay, floor_raw, hold);
  endtask

  // mostly a falling walk per band with spikes and full-scale hits
  function automatic logic signed [LEVEL_W-1:0] next_level(logic [BAND_W-1:0] b);
    int v;
    case ($urandom_range(19))
      0: v = -32768;
      1: v = 32767;
      2, 3: v = int'($urandom_range(65535)) - 32768;
      default: v = walk[b] + int'($urandom_range(1000)) - 650;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    walk[b] = v;
    return LEVEL_W'(v);
  endfunction

  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int span;
    int base;
    logic [BAND_W-1:0] b;
    foreach (walk[i]) walk[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: full-scale jump, slow fall, decay floored at the level
    send_frame(6'd0, 16'sh7fff);
    send_frame(6'd0, 16'sh8000);
    send_frame(6'd63, 16'sh8000);
    send_frame(6'd63, 16'sd0);
    send_frame(6'd5, -16'sd15360);
    wait_drained();
    write_reg(CFG_UNUSED, 16'h5a5a);
    apply_setting(16'hffff, 16'h8000, 10'd0);
    send_frame(6'd1, 16'sh7fff);
    repeat (3) send_frame(6'd1, 16'sh8000);
    wait_drained();
    // odd step, short hold: countdown runs out, half step rounds down
    apply_setting(16'd3, 16'h8000, 10'd2);
    send_frame(6'd3, 16'sd1000);
    repeat (3) send_frame(6'd3, 16'sd0);
    wait_drained();
    // raised floor applies on the next decay and lifts a low peak
    apply_setting(16'd3, 16'h7fff, 10'd1023);
    send_frame(6'd3, 16'sd0);
    send_frame(6'd2, 16'sh8000);
    send_frame(6'd2, 16'sd100);
    send_frame(6'd4, 16'sd500);
    send_frame(6'd4, 16'sd400);
    wait_drained();
    apply_setting(16'd0, 16'hc400, 10'd1023);
    send_frame(6'd6, -16'sd100);
    send_frame(6'd6, -16'sd200);
    send_frame(6'd6, -16'sd100);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      pick_setting(ph);
      span = ($urandom_range(4) == 0) ? 64 : $urandom_range(1, 8);
      base = $urandom_range(63);
      b = BAND_W'(base);
      for (int n = 0; n < RANDOM_FRAMES / PHASES; n++) begin
        if ($urandom_range(9) < 7) b = BAND_W'(base + $urandom_range(span - 1));
        send_frame(b, next_level(b));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
